[design/vlrs_pkg.sv]
// vlrs_pkg: shared constants, item structs and the controller/datapath
// command and status bundles of the variable-length record stack.
// No dependencies.
`default_nettype none

package vlrs_pkg;

  localparam int CAPACITY         = 256;
  localparam int MAX_RECORD_BYTES = 32;
  localparam int HEADER_BYTES     = 4;
  localparam int MAX_OUT          = 32;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int FREE_W = $clog2(CAPACITY + 1);
  localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int LEN_W  = 6;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_PEEK  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // source of stored_length on a result without data
  localparam logic [1:0] SLEN_ZERO  = 2'd0;
  localparam logic [1:0] SLEN_PUSH  = 2'd1;
  localparam logic [1:0] SLEN_RDATA = 2'd2;
  localparam logic [1:0] SLEN_POP   = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] record_length;
    logic [LEN_W-1:0] requested_length;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [7:0]       out_byte;
    logic             has_data;
    logic             last;
    logic [LEN_W-1:0] stored_length;
    logic             is_empty;
    logic [8:0]       free_bytes;
  } out_item_t;

  typedef struct packed {
    logic       take_in;
    logic       push_start;
    logic       hdr_wr;
    logic       data_wr;
    logic       push_end;
    logic       abandon;
    logic       clear_stack;
    logic       rd_hdr;
    logic       load_len;
    logic       rd_first;
    logic       emit_single;
    logic       emit_ok;
    logic [1:0] slen_src;
    logic       emit_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       item_last;
    logic       push_active;
    logic       push_accepted;
    logic       push_fits;
    logic       is_empty;
    logic       hdr_last;
    logic       n_zero;
    logic       byte_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/vlrs_dp.sv]
// vlrs_dp: datapath of the record stack: byte store, free counter, push
// bookkeeping, read sequencing and the output register.
// Depends on vlrs_pkg.
`default_nettype none

module vlrs_dp import vlrs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire cmd_t      cmd,
  output sts_t           sts,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [7:0] mem [0:CAPACITY-1];
  logic [7:0] rdata_r;

  in_item_t          item_r, item_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic              push_active_r, push_active_nxt;
  logic              push_accepted_r, push_accepted_nxt;
  logic [LEN_W-1:0]  push_count_r, push_count_nxt;
  logic [ADDR_W-1:0] record_base_r, record_base_nxt;
  logic [LEN_W-1:0]  push_len_r, push_len_nxt;
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0]  slen_r, slen_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              is_empty;
  logic              push_fits;
  logic [FREE_W-1:0] need;
  logic              hdr_last;
  logic              byte_last;
  logic [7:0]        nmin;
  logic [7:0]        ncap;
  logic [FREE_W:0]   pop_free;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic [ADDR_W-1:0] data_base;
  logic [LEN_W-1:0]  slen_sel;

  assign is_empty  = free_r >= FREE_W'(CAPACITY);
  assign need      = FREE_W'(item_r.record_length) + FREE_W'(HEADER_BYTES);
  assign push_fits = (7'(item_r.record_length) <= 7'(MAX_RECORD_BYTES)) && (free_r >= need);
  assign hdr_last  = hcnt_r == HCNT_W'(HEADER_BYTES - 1);
  assign byte_last = LEN_W'(idx_r + LEN_W'(1)) == n_r;
  assign data_base = record_base_r + ADDR_W'(HEADER_BYTES);

  // bytes to emit: min(stored, requested), capped
  assign nmin = (rdata_r < {2'b00, item_r.requested_length}) ?
                rdata_r : {2'b00, item_r.requested_length};
  assign ncap = (nmin > 8'(MAX_OUT)) ? 8'(MAX_OUT) : nmin;

  assign pop_free = {1'b0, free_r} + (FREE_W+1)'(HEADER_BYTES) + (FREE_W+1)'(rdata_r);

  always_comb begin
    mem_we = cmd.hdr_wr |
             (cmd.data_wr & push_accepted_r & (push_count_r < push_len_r));
    mem_wa = cmd.hdr_wr ? (record_base_r + ADDR_W'(hcnt_r))
                        : (data_base + ADDR_W'(push_count_r));
    if (cmd.hdr_wr) begin
      mem_wd = (hcnt_r == '0) ? {2'b00, push_len_r} : 8'h00;
    end else begin
      mem_wd = item_r.data_byte;
    end
    mem_re = cmd.rd_hdr | cmd.rd_first | (cmd.emit_byte & ~byte_last);
    if (cmd.rd_hdr) begin
      mem_ra = free_r[ADDR_W-1:0];
    end else if (cmd.rd_first) begin
      mem_ra = data_base;
    end else begin
      mem_ra = data_base + ADDR_W'(idx_r) + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_comb begin
    case (cmd.slen_src)
      SLEN_PUSH:  slen_sel = push_len_r;
      SLEN_RDATA: slen_sel = rdata_r[LEN_W-1:0];
      SLEN_POP:   slen_sel = slen_r;
      default:    slen_sel = '0;
    endcase
  end

  always_comb begin
    item_nxt          = item_r;
    free_nxt          = free_r;
    push_active_nxt   = push_active_r;
    push_accepted_nxt = push_accepted_r;
    push_count_nxt    = push_count_r;
    record_base_nxt   = record_base_r;
    push_len_nxt      = push_len_r;
    hcnt_nxt          = hcnt_r;
    slen_nxt          = slen_r;
    n_nxt             = n_r;
    idx_nxt           = idx_r;
    out_valid_nxt     = out_valid_r & out_stall;
    out_data_nxt      = out_data_r;

    if (cmd.take_in) begin
      item_nxt = in_data;
    end
    if (cmd.push_start) begin
      push_active_nxt   = 1'b1;
      push_accepted_nxt = push_fits;
      push_count_nxt    = '0;
      hcnt_nxt          = '0;
      if (push_fits) begin
        record_base_nxt = ADDR_W'(free_r - need);
        push_len_nxt    = item_r.record_length;
      end
    end
    if (cmd.hdr_wr) begin
      hcnt_nxt = hcnt_r + HCNT_W'(1);
    end
    if (cmd.data_wr && push_accepted_r && (push_count_r < push_len_r)) begin
      push_count_nxt = push_count_r + LEN_W'(1);
    end
    if (cmd.push_end) begin
      push_active_nxt = 1'b0;
      push_count_nxt  = '0;
      if (push_accepted_r) begin
        free_nxt = FREE_W'(record_base_r);
      end
    end
    if (cmd.abandon) begin
      push_active_nxt   = 1'b0;
      push_accepted_nxt = 1'b0;
      push_count_nxt    = '0;
    end
    if (cmd.clear_stack) begin
      free_nxt = FREE_W'(CAPACITY);
    end
    if (cmd.rd_hdr) begin
      record_base_nxt = free_r[ADDR_W-1:0];
    end
    if (cmd.load_len) begin
      slen_nxt = rdata_r[LEN_W-1:0];
      n_nxt    = LEN_W'(ncap);
      idx_nxt  = '0;
      if (item_r.action == ACT_POP) begin
        free_nxt = (pop_free > (FREE_W+1)'(CAPACITY)) ? FREE_W'(CAPACITY)
                                                      : FREE_W'(pop_free);
      end
    end
    if (cmd.emit_single) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.ok            = cmd.emit_ok;
      out_data_nxt.out_byte      = 8'h00;
      out_data_nxt.has_data      = 1'b0;
      out_data_nxt.last          = 1'b1;
      out_data_nxt.stored_length = slen_sel;
      out_data_nxt.is_empty      = is_empty;
      out_data_nxt.free_bytes    = 9'(free_r);
    end
    if (cmd.emit_byte) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.ok            = 1'b1;
      out_data_nxt.out_byte      = rdata_r;
      out_data_nxt.has_data      = 1'b1;
      out_data_nxt.last          = byte_last;
      out_data_nxt.stored_length = slen_r;
      out_data_nxt.is_empty      = is_empty;
      out_data_nxt.free_bytes    = 9'(free_r);
      if (!byte_last) begin
        idx_nxt = idx_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r          <= FREE_W'(CAPACITY);
      push_active_r   <= 1'b0;
      push_accepted_r <= 1'b0;
      push_count_r    <= '0;
      record_base_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      free_r          <= free_nxt;
      push_active_r   <= push_active_nxt;
      push_accepted_r <= push_accepted_nxt;
      push_count_r    <= push_count_nxt;
      record_base_r   <= record_base_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    push_len_r <= push_len_nxt;
    hcnt_r     <= hcnt_nxt;
    slen_r     <= slen_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.action        = item_r.action;
    sts.item_last     = item_r.last_byte;
    sts.push_active   = push_active_r;
    sts.push_accepted = push_accepted_r;
    sts.push_fits     = push_fits;
    sts.is_empty      = is_empty;
    sts.hdr_last      = hdr_last;
    sts.n_zero        = ncap == 8'h00;
    sts.byte_last     = byte_last;
    sts.out_free      = ~out_valid_r | ~out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/vlrs_ctrl.sv]
// vlrs_ctrl: state machine sequencing push, pop, peek and clear over the
// datapath through command and status bundles.
// Depends on vlrs_pkg.
`default_nettype none

module vlrs_ctrl import vlrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_HDR     = 4'd2;
  localparam logic [3:0] S_DATA    = 4'd3;
  localparam logic [3:0] S_PRES    = 4'd4;
  localparam logic [3:0] S_LEN     = 4'd5;
  localparam logic [3:0] S_BYTE    = 4'd6;
  localparam logic [3:0] S_TLEN    = 4'd7;
  localparam logic [3:0] S_EM_FAIL = 4'd8;
  localparam logic [3:0] S_EM_CLR  = 4'd9;
  localparam logic [3:0] S_EM_PUSH = 4'd10;
  localparam logic [3:0] S_EM_SLEN = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          ACT_PUSH: begin
            if (!sts.push_active) begin
              cmd.push_start = 1'b1;
              state_nxt      = sts.push_fits ? S_HDR : S_DATA;
            end else begin
              state_nxt = S_DATA;
            end
          end
          ACT_CLEAR: begin
            cmd.abandon     = 1'b1;
            cmd.clear_stack = 1'b1;
            state_nxt       = S_EM_CLR;
          end
          default: begin
            cmd.abandon = 1'b1;
            if (sts.is_empty) begin
              state_nxt = S_EM_FAIL;
            end else begin
              cmd.rd_hdr = 1'b1;
              state_nxt  = S_LEN;
            end
          end
        endcase
      end
      S_HDR: begin
        cmd.hdr_wr = 1'b1;
        if (sts.hdr_last) begin
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        cmd.data_wr = 1'b1;
        if (sts.item_last) begin
          cmd.push_end = 1'b1;
          state_nxt    = S_PRES;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PRES: begin
        // refused push on a non-empty stack reports the top header
        if (sts.push_accepted) begin
          state_nxt = S_EM_PUSH;
        end else if (sts.is_empty) begin
          state_nxt = S_EM_FAIL;
        end else begin
          cmd.rd_hdr = 1'b1;
          state_nxt  = S_TLEN;
        end
      end
      S_LEN: begin
        cmd.load_len = 1'b1;
        if (sts.n_zero) begin
          state_nxt = S_EM_SLEN;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_BYTE;
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.byte_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_TLEN: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          cmd.emit_ok     = 1'b0;
          cmd.slen_src    = SLEN_RDATA;
          state_nxt       = S_IDLE;
        end
      end
      S_EM_FAIL: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          cmd.emit_ok     = 1'b0;
          cmd.slen_src    = SLEN_ZERO;
          state_nxt       = S_IDLE;
        end
      end
      S_EM_CLR: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          cmd.emit_ok     = 1'b1;
          cmd.slen_src    = SLEN_ZERO;
          state_nxt       = S_IDLE;
        end
      end
      S_EM_PUSH: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          cmd.emit_ok     = 1'b1;
          cmd.slen_src    = SLEN_PUSH;
          state_nxt       = S_IDLE;
        end
      end
      S_EM_SLEN: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          cmd.emit_ok     = 1'b1;
          cmd.slen_src    = SLEN_POP;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/variable_length_record_stack.sv]
// Variable-length record stack, one item at a time through a 256-byte store.
// Push item: each item passes IDLE, DISP and DATA; the first item of an accepted
// record adds the HEADER_BYTES header writes in S_HDR; the final push item adds
// the result. Pop/peek: header read then one byte per cycle from the store read
// port while the output is not stalled. Clear: empties the stack, reports ok.
// Reset (synchronous, rst_n low) empties the stack; store contents are kept.
`default_nettype none

module variable_length_record_stack import vlrs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  vlrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vlrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  a_one_store_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.hdr_wr, cmd.data_wr, cmd.rd_hdr, cmd.rd_first,
              cmd.emit_byte, cmd.emit_single}))
    else $error("conflicting store or emit commands");

  a_data_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_data |-> out_data.ok && (out_data.stored_length != '0))
    else $error("data byte without a stored record");

  a_empty_all_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.free_bytes == 9'(CAPACITY))
    else $error("empty stack with bytes in use");
`endif

endmodule

`default_nettype wire
